// File: rtl/colmap_pkg.sv
package colmap_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int SAMPLE_W = 18;
	localparam int CHAN_W = 8;
	localparam int MAP_W = 2;

	typedef enum logic [MAP_W-1:0] {
		MAP_TURBO     = 2'd0,
		MAP_GRAY      = 2'd1,
		MAP_DIVERGING = 2'd2,
		MAP_WATER     = 2'd3
	} map_sel_t;

	// per-beat control that rides along the pipeline
	typedef struct packed {
		map_sel_t map;
		logic     upper;
	} stage_ctl_t;

endpackage

// File: rtl/colmap_clamp.sv
module colmap_clamp #(
	parameter int FRACTION_BITS = colmap_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [colmap_pkg::SAMPLE_W-1:0] sample_value,
	input  colmap_pkg::map_sel_t                map_select,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [FRACTION_BITS:0]              t,
	output colmap_pkg::map_sel_t                map_o
);

	localparam int MAG_W = colmap_pkg::SAMPLE_W - 1;
	localparam int TW = FRACTION_BITS + 1;
	localparam int CW = (TW > MAG_W) ? TW : MAG_W;
	localparam logic [CW-1:0] ONE_C = CW'(1) << FRACTION_BITS;

	logic [CW-1:0] mag;
	logic [CW-1:0] clamp_c;
	logic          vld_s1;
	logic [TW-1:0] t_s1;
	colmap_pkg::map_sel_t map_s1;

	assign mag = CW'(sample_value[MAG_W-1:0]);
	// negative samples go to zero, anything above one saturates at one
	assign clamp_c = sample_value[colmap_pkg::SAMPLE_W-1] ? '0 :
		((mag > ONE_C) ? ONE_C : mag);

	assign in_ready = !vld_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			t_s1   <= clamp_c[TW-1:0];
			map_s1 <= map_select;
		end
	end

	assign out_valid = vld_s1;
	assign t = t_s1;
	assign map_o = map_s1;

endmodule

// File: rtl/colmap_operand.sv
module colmap_operand #(
	parameter int FRACTION_BITS = colmap_pkg::FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [FRACTION_BITS:0]       t,
	input  colmap_pkg::map_sel_t         map_i,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [FRACTION_BITS+1:0]     x0,
	output logic [FRACTION_BITS+1:0]     x1,
	output logic [FRACTION_BITS+1:0]     x2,
	output logic [2*FRACTION_BITS+1:0]   tt,
	output colmap_pkg::stage_ctl_t       ctl
);

	localparam int TW = FRACTION_BITS + 1;
	localparam int XW = FRACTION_BITS + 2;
	localparam int QW = 2 * FRACTION_BITS + 2;
	localparam logic [XW-1:0] S_X = XW'(1) << FRACTION_BITS;
	localparam logic [XW-1:0] TWO_S = XW'(1) << (FRACTION_BITS + 1);

	// min(3n, 2s): turbo ramp scaled by 1.5 and saturated at one
	function automatic logic [XW-1:0] turbo_sat(input logic [XW-1:0] n);
		logic [XW:0] n3;
		n3 = {1'b0, n} + {n, 1'b0};
		turbo_sat = (n3 > {1'b0, TWO_S}) ? TWO_S : n3[XW-1:0];
	endfunction

	logic [XW-1:0] tx;
	logic [XW-1:0] t2;
	logic          upper_c;
	logic [XW-1:0] tent;
	logic [XW-1:0] x0_c, x1_c, x2_c;

	logic          vld_s2;
	logic [XW-1:0] x0_s2, x1_s2, x2_s2;
	logic [QW-1:0] tt_s2;
	colmap_pkg::stage_ctl_t ctl_s2;

	assign tx = XW'(t);
	assign t2 = {t, 1'b0};
	assign upper_c = (t2 >= S_X);
	// |2t - s|, the turbo tent distance and the diverging branch offset
	assign tent = upper_c ? (t2 - S_X) : (S_X - t2);

	always_comb begin
		unique case (map_i)
			colmap_pkg::MAP_TURBO: begin
				x0_c = turbo_sat(tx);
				x1_c = turbo_sat(S_X - tent);
				x2_c = turbo_sat(S_X - tx);
			end
			colmap_pkg::MAP_DIVERGING: begin
				if (upper_c) begin
					x0_c = tent;
					x1_c = S_X - tent;
					x2_c = S_X - tent;
				end else begin
					x0_c = S_X - tent;
					x1_c = S_X - tent;
					x2_c = tent;
				end
			end
			colmap_pkg::MAP_GRAY, colmap_pkg::MAP_WATER: begin
				x0_c = tx;
				x1_c = tx;
				x2_c = tx;
			end
		endcase
	end

	assign in_ready = !vld_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (in_ready) begin
			vld_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x0_s2        <= x0_c;
			x1_s2        <= x1_c;
			x2_s2        <= x2_c;
			tt_s2        <= QW'(t) * QW'(t);
			ctl_s2.map   <= map_i;
			ctl_s2.upper <= upper_c;
		end
	end

	assign out_valid = vld_s2;
	assign x0 = x0_s2;
	assign x1 = x1_s2;
	assign x2 = x2_s2;
	assign tt = tt_s2;
	assign ctl = ctl_s2;

endmodule

// File: rtl/colmap_numer.sv
module colmap_numer #(
	parameter int FRACTION_BITS = colmap_pkg::FRACTION_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [FRACTION_BITS+1:0]      x0,
	input  logic [FRACTION_BITS+1:0]      x1,
	input  logic [FRACTION_BITS+1:0]      x2,
	input  logic [2*FRACTION_BITS+1:0]    tt,
	input  colmap_pkg::stage_ctl_t        ctl_i,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2*FRACTION_BITS+9:0]    num0,
	output logic [2*FRACTION_BITS+9:0]    num1,
	output logic [2*FRACTION_BITS+9:0]    num2,
	output colmap_pkg::stage_ctl_t        ctl
);

	localparam int NW = 2 * FRACTION_BITS + 10;
	// constant offsets, integer multiples of s (or s squared)
	localparam logic [NW-1:0] OFS_204 = NW'(204) << FRACTION_BITS;
	localparam logic [NW-1:0] OFS_306 = NW'(306) << FRACTION_BITS;
	localparam logic [NW-1:0] OFS_408 = NW'(408) << FRACTION_BITS;
	localparam logic [NW-1:0] OFS_459 = NW'(459) << FRACTION_BITS;
	localparam logic [NW-1:0] OFS_195 = NW'(195) << FRACTION_BITS;
	localparam logic [NW-1:0] OFS_70SQ = NW'(70) << (2 * FRACTION_BITS);

	logic [NW-1:0] xn0, xn1, xn2, ttn;
	logic [NW-1:0] n0_c, n1_c, n2_c;

	logic          vld_s3;
	logic [NW-1:0] n0_s3, n1_s3, n2_s3;
	colmap_pkg::stage_ctl_t ctl_s3;

	assign xn0 = NW'(x0);
	assign xn1 = NW'(x1);
	assign xn2 = NW'(x2);
	assign ttn = NW'(tt);

	always_comb begin
		unique case (ctl_i.map)
			colmap_pkg::MAP_TURBO, colmap_pkg::MAP_GRAY: begin
				n0_c = NW'(255) * xn0;
				n1_c = NW'(255) * xn1;
				n2_c = NW'(255) * xn2;
			end
			colmap_pkg::MAP_DIVERGING: begin
				if (ctl_i.upper) begin
					n0_c = OFS_408 + NW'(612) * xn0;
					n1_c = OFS_204 + NW'(510) * xn1;
					n2_c = OFS_204 + NW'(408) * xn2;
				end else begin
					n0_c = OFS_204 + NW'(408) * xn0;
					n1_c = OFS_306 + NW'(510) * xn1;
					n2_c = OFS_459 + NW'(561) * xn2;
				end
			end
			colmap_pkg::MAP_WATER: begin
				n0_c = NW'(120) * xn0;
				n1_c = OFS_70SQ + NW'(180) * ttn;
				n2_c = OFS_195 + NW'(60) * xn2;
			end
		endcase
	end

	assign in_ready = !vld_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (in_ready) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			n0_s3  <= n0_c;
			n1_s3  <= n1_c;
			n2_s3  <= n2_c;
			ctl_s3 <= ctl_i;
		end
	end

	assign out_valid = vld_s3;
	assign num0 = n0_s3;
	assign num1 = n1_s3;
	assign num2 = n2_s3;
	assign ctl = ctl_s3;

endmodule

// File: rtl/colmap_scale.sv
module colmap_scale #(
	parameter int FRACTION_BITS = colmap_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2*FRACTION_BITS+9:0]          num0,
	input  logic [2*FRACTION_BITS+9:0]          num1,
	input  logic [2*FRACTION_BITS+9:0]          num2,
	input  colmap_pkg::stage_ctl_t              ctl_i,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [colmap_pkg::CHAN_W-1:0]       red,
	output logic [colmap_pkg::CHAN_W-1:0]       green,
	output logic [colmap_pkg::CHAN_W-1:0]       blue
);

	localparam int NW = 2 * FRACTION_BITS + 10;
	localparam int CW = colmap_pkg::CHAN_W;
	localparam logic [NW-1:0] CHAN_MAX = NW'((1 << CW) - 1);

	function automatic logic [CW-1:0] sat_chan(input logic [NW-1:0] v);
		sat_chan = (v > CHAN_MAX) ? CHAN_MAX[CW-1:0] : v[CW-1:0];
	endfunction

	logic [NW-1:0] q0, q1, q2;

	logic          vld_s4;
	logic [CW-1:0] red_s4, green_s4, blue_s4;
	colmap_pkg::map_sel_t map_s4;

	// floor by the denominator of each map: 2s, s, 4s, s (s squared for water green)
	always_comb begin
		unique case (ctl_i.map)
			colmap_pkg::MAP_TURBO: begin
				q0 = num0 >> (FRACTION_BITS + 1);
				q1 = num1 >> (FRACTION_BITS + 1);
				q2 = num2 >> (FRACTION_BITS + 1);
			end
			colmap_pkg::MAP_GRAY: begin
				q0 = num0 >> FRACTION_BITS;
				q1 = num1 >> FRACTION_BITS;
				q2 = num2 >> FRACTION_BITS;
			end
			colmap_pkg::MAP_DIVERGING: begin
				q0 = num0 >> (FRACTION_BITS + 2);
				q1 = num1 >> (FRACTION_BITS + 2);
				q2 = num2 >> (FRACTION_BITS + 2);
			end
			colmap_pkg::MAP_WATER: begin
				q0 = num0 >> FRACTION_BITS;
				q1 = num1 >> (2 * FRACTION_BITS);
				q2 = num2 >> FRACTION_BITS;
			end
		endcase
	end

	assign in_ready = !vld_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (in_ready) begin
			vld_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			red_s4   <= sat_chan(q0);
			green_s4 <= sat_chan(q1);
			blue_s4  <= sat_chan(q2);
			map_s4   <= ctl_i.map;
		end
	end

	assign out_valid = vld_s4;
	assign red = red_s4;
	assign green = green_s4;
	assign blue = blue_s4;

	// grayscale beats carry one value on all three channels
	a_gray_equal: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && map_s4 == colmap_pkg::MAP_GRAY |-> red_s4 == green_s4 && green_s4 == blue_s4)
		else $error("gray beat with unequal channels");

	// water map bounds: red at most 120, green at least 70, blue at least 195
	a_water_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && map_s4 == colmap_pkg::MAP_WATER |->
		red_s4 <= CW'(120) && green_s4 >= CW'(70) && blue_s4 >= CW'(195))
		else $error("water beat out of range");

	// diverging map never drops below its base levels
	a_div_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && map_s4 == colmap_pkg::MAP_DIVERGING |->
		red_s4 >= CW'(51) && green_s4 >= CW'(51) && blue_s4 >= CW'(51))
		else $error("diverging beat below base level");

endmodule

// File: rtl/scalar_to_rgb_colormap_core.sv
// Scalar to RGB false-color map. Each beat on the input carries one signed sample in units of
// 2^-FRACTION_BITS; it is clamped to 0..1 and mapped to an 8-bit red, green and blue through
// the map chosen by the configuration register (turbo-like, grayscale, diverging or water).
// The datapath is a four-stage pipeline (clamp, operand, numerator, scale and saturate) that
// takes one beat per clock while the output is not stalled; each beat passes through the
// clamp, operand, numerator and scale registers in order. Backpressure on the output holds
// every occupied stage in place. The map choice travels with each beat, so a configuration
// write affects only beats accepted after it; the configuration port is always ready.
module scalar_to_rgb_colormap_core #(
	parameter int FRACTION_BITS = colmap_pkg::FRACTION_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [colmap_pkg::MAP_W-1:0]           cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [colmap_pkg::SAMPLE_W-1:0] sample_value,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [colmap_pkg::CHAN_W-1:0]          red,
	output logic [colmap_pkg::CHAN_W-1:0]          green,
	output logic [colmap_pkg::CHAN_W-1:0]          blue
);

	localparam int XW = FRACTION_BITS + 2;
	localparam int QW = 2 * FRACTION_BITS + 2;
	localparam int NW = 2 * FRACTION_BITS + 10;

	colmap_pkg::map_sel_t map_select_q;

	logic                     v1, r1, v2, r2, v3, r3;
	logic [FRACTION_BITS:0]   t1;
	colmap_pkg::map_sel_t     map1;
	logic [XW-1:0]            x0, x1, x2;
	logic [QW-1:0]            tt;
	colmap_pkg::stage_ctl_t   ctl2, ctl3;
	logic [NW-1:0]            num0, num1, num2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_select_q <= colmap_pkg::MAP_TURBO;
		end else if (cfg_valid && cfg_ready) begin
			map_select_q <= colmap_pkg::map_sel_t'(cfg_data);
		end
	end

	colmap_clamp #(.FRACTION_BITS(FRACTION_BITS)) u_clamp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample_value (sample_value),
		.map_select   (map_select_q),
		.out_valid    (v1),
		.out_ready    (r1),
		.t            (t1),
		.map_o        (map1)
	);

	colmap_operand #(.FRACTION_BITS(FRACTION_BITS)) u_operand (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v1),
		.in_ready  (r1),
		.t         (t1),
		.map_i     (map1),
		.out_valid (v2),
		.out_ready (r2),
		.x0        (x0),
		.x1        (x1),
		.x2        (x2),
		.tt        (tt),
		.ctl       (ctl2)
	);

	colmap_numer #(.FRACTION_BITS(FRACTION_BITS)) u_numer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v2),
		.in_ready  (r2),
		.x0        (x0),
		.x1        (x1),
		.x2        (x2),
		.tt        (tt),
		.ctl_i     (ctl2),
		.out_valid (v3),
		.out_ready (r3),
		.num0      (num0),
		.num1      (num1),
		.num2      (num2),
		.ctl       (ctl3)
	);

	colmap_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v3),
		.in_ready  (r3),
		.num0      (num0),
		.num1      (num1),
		.num2      (num2),
		.ctl_i     (ctl3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	// an empty or draining output stage frees the whole pipeline
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input stalled with output free");

endmodule

// File: sim/tb_scalar_to_rgb_colormap_core.sv
`timescale 1ns / 1ps

module tb_scalar_to_rgb_colormap_core;

	localparam int FRAC = colmap_pkg::FRACTION_BITS_DEF;
	localparam int CHW = colmap_pkg::CHAN_W;
	localparam int SW = colmap_pkg::SAMPLE_W;
	localparam int PHASE_ITEMS = 190;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic [CHW-1:0] r;
		logic [CHW-1:0] g;
		logic [CHW-1:0] b;
	} rgb_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [colmap_pkg::MAP_W-1:0]   cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic signed [SW-1:0]           sample_value = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [CHW-1:0]                 red;
	logic [CHW-1:0]                 green;
	logic [CHW-1:0]                 blue;

	logic signed [SW-1:0]           sample_q[$];
	rgb_t                           rgb_expect_q[$];
	colmap_pkg::map_sel_t           active_map = colmap_pkg::MAP_TURBO;
	bit                             in_fire = 1'b0;
	bit                             calm = 1'b0;
	bit                             hold_req = 1'b0;
	int                             hold_left = 0;
	int                             idle_cycles = 0;
	int                             errors = 0;
	int                             colors_checked = 0;
	int                             cfg_writes = 0;
	int                             samples_per_map[4] = '{0, 0, 0, 0};

	scalar_to_rgb_colormap_core #(
		.FRACTION_BITS(FRAC)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_value(sample_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor(255 * min(1.5 * n / s, 1))
	function automatic longint unsigned turbo_ramp(longint unsigned n, longint unsigned s);
		longint unsigned tri3;
		tri3 = 3 * n;
		if (tri3 > 2 * s)
			tri3 = 2 * s;
		return tri3 * 255 / (2 * s);
	endfunction

	function automatic logic [CHW-1:0] sat8(longint unsigned v);
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic rgb_t colormap_rgb(colmap_pkg::map_sel_t m, logic signed [SW-1:0] x);
		longint unsigned s, t, twice, tent, k, a, den, c0, c1, c2;
		rgb_t o;
		s = 64'd1 << FRAC;
		// clamp to 0..1
		if (x[SW-1])
			t = 0;
		else
			t = x;
		if (t > s)
			t = s;
		den = 4 * s;
		case (m)
			colmap_pkg::MAP_TURBO: begin
				twice = 2 * t;
				tent = (twice >= s) ? twice - s : s - twice;
				c0 = turbo_ramp(t, s);
				c1 = turbo_ramp(s - tent, s);
				c2 = turbo_ramp(s - t, s);
			end
			colmap_pkg::MAP_GRAY: begin
				c0 = t * 255 / s;
				c1 = c0;
				c2 = c0;
			end
			colmap_pkg::MAP_DIVERGING: begin
				// exact half goes to the upper branch
				if (2 * t >= s) begin
					k = 2 * t - s;
					c0 = (408 * s + 612 * k) / den;
					c1 = (204 * s + 510 * (s - k)) / den;
					c2 = (204 * s + 408 * (s - k)) / den;
				end else begin
					a = s - 2 * t;
					c0 = (204 * s + 408 * (s - a)) / den;
					c1 = (306 * s + 510 * (s - a)) / den;
					c2 = (459 * s + 561 * a) / den;
				end
			end
			default: begin
				c0 = 120 * t / s;
				c1 = (180 * t * t + 70 * s * s) / (s * s);
				c2 = (60 * t + 195 * s) / s;
			end
		endcase
		o.r = sat8(c0);
		o.g = sat8(c1);
		o.b = sat8(c2);
		return o;
	endfunction

	// clamp edges, turbo knees, diverging midpoint and sign extremes
	function automatic logic signed [SW-1:0] edge_sample(int i);
		case (i)
			0:  return 18'h20000;
			1:  return 18'h3FFFF;
			2:  return 18'sd0;
			3:  return 18'sd1;
			4:  return 18'sd21845;
			5:  return 18'sd21846;
			6:  return 18'sd32767;
			7:  return 18'sd32768;
			8:  return 18'sd32769;
			9:  return 18'sd43690;
			10: return 18'sd43691;
			11: return 18'sd65535;
			12: return 18'sd65536;
			13: return 18'sd65537;
			default: return 18'h1FFFF;
		endcase
	endfunction

	function automatic logic signed [SW-1:0] random_sample();
		case ($urandom_range(7))
			0:       return edge_sample($urandom_range(14));
			1, 2:    return 18'($urandom);
			default: return 18'($urandom_range(65536));
		endcase
	endfunction

	// sender: next beat offered at the falling edge once the last one was taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
				in_valid <= 1'b1;
				sample_value <= sample_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && (calm || $urandom_range(99) >= 15);
		end
	end

	always @(posedge clk) begin
		rgb_t want;
		bit   out_fire;
		bit   cfg_fire;
		if (!arst_n) begin
			in_fire = 1'b0;
		end else begin
			in_fire = in_valid && in_ready;
			out_fire = out_valid && out_ready;
			cfg_fire = cfg_valid && cfg_ready;
			if (in_fire) begin
				rgb_expect_q.push_back(colormap_rgb(active_map, sample_value));
				samples_per_map[active_map]++;
			end
			if (cfg_fire) begin
				active_map = colmap_pkg::map_sel_t'(cfg_data);
				cfg_writes++;
			end
			if (out_fire) begin
				if (rgb_expect_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected color beat r=%0d g=%0d b=%0d", red, green, blue);
				end else begin
					want = rgb_expect_q.pop_front();
					colors_checked++;
					if (red !== want.r || green !== want.g || blue !== want.b) begin
						errors++;
						if (errors <= 10)
							$display("color %0d mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
								colors_checked, want.r, want.g, want.b, red, green, blue);
					end
				end
			end
			if (in_fire || out_fire || cfg_fire)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d colors outstanding",
					idle_cycles, rgb_expect_q.size());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic drain();
		while (sample_q.size() != 0 || in_valid || rgb_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_map(colmap_pkg::map_sel_t m);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		colmap_pkg::map_sel_t plan[8];
		plan = '{colmap_pkg::MAP_GRAY, colmap_pkg::MAP_DIVERGING, colmap_pkg::MAP_WATER,
			colmap_pkg::MAP_TURBO, colmap_pkg::MAP_WATER, colmap_pkg::MAP_DIVERGING,
			colmap_pkg::MAP_GRAY, colmap_pkg::MAP_TURBO};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset map first, walk the edge samples
		for (int i = 0; i < 15; i++)
			sample_q.push_back(edge_sample(i));
		drain();

		for (int p = 0; p < 8; p++) begin
			write_map(plan[p]);
			calm = (p == 2);
			for (int i = 0; i < 15; i++)
				sample_q.push_back(edge_sample(i));
			for (int i = 0; i < PHASE_ITEMS; i++)
				sample_q.push_back(random_sample());
			// long output stall while the sender keeps pushing
			if (p == 4) begin
				@(posedge clk);
				hold_req = 1'b1;
			end
			drain();
		end
		calm = 1'b0;

		errors += rgb_expect_q.size();
		$display("covered turbo %0d, gray %0d, diverging %0d, water %0d samples",
			samples_per_map[colmap_pkg::MAP_TURBO], samples_per_map[colmap_pkg::MAP_GRAY],
			samples_per_map[colmap_pkg::MAP_DIVERGING], samples_per_map[colmap_pkg::MAP_WATER]);
		$display("%0d map writes, %0d colors checked, %0d errors",
			cfg_writes, colors_checked, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
